/* design/mp2d_pkg.sv */
// ----------------------------------------------------------------------------
// mp2d_pkg: shared definitions for the 2-D max pooling core
// Widths, register indexes, store addressing and the float compare.
// ----------------------------------------------------------------------------
`default_nettype none

package mp2d_pkg;

    localparam int MAX_CHANNELS   = 512;
    localparam int MAX_OUT_WIDTH  = 32;
    localparam int ROWS_IN_FLIGHT = 4;
    localparam int MAX_WINDOW     = 4;
    localparam int MAX_IN_WIDTH   = 128;

    localparam int CH_W    = $clog2(MAX_CHANNELS);
    localparam int OCOL_W  = $clog2(MAX_OUT_WIDTH);
    localparam int SLOT_W  = $clog2(ROWS_IN_FLIGHT);
    localparam int ADDR_W  = SLOT_W + OCOL_W + CH_W;
    localparam int DEPTH   = ROWS_IN_FLIGHT * MAX_OUT_WIDTH * MAX_CHANNELS;

    localparam int POS_W   = 7;   // column and row position counters
    localparam int STEP_W  = 3;   // window sizes and strides
    localparam int OFS_W   = 4;   // offset inside a window while scanning
    localparam int DCNT_W  = $clog2(POS_W);
    localparam int DATA_W  = 32;
    localparam int CFG_W   = 10;

    localparam logic [2:0] REG_CHANNEL_COUNT = 3'd0;
    localparam logic [2:0] REG_INPUT_WIDTH   = 3'd1;
    localparam logic [2:0] REG_OUTPUT_WIDTH  = 3'd2;
    localparam logic [2:0] REG_OUTPUT_HEIGHT = 3'd3;
    localparam logic [2:0] REG_WINDOW_WIDTH  = 3'd4;
    localparam logic [2:0] REG_WINDOW_HEIGHT = 3'd5;
    localparam logic [2:0] REG_STEP_X        = 3'd6;
    localparam logic [2:0] REG_STEP_Y        = 3'd7;

    typedef struct packed {
        logic              done;
        logic [POS_W-1:0]  quot;
        logic [STEP_W-1:0] rem;
    } div_res_t;

    // True when the stored value is strictly greater than the fresh one.
    // Unordered operands (NaN) and equal values, including both zeros,
    // give false.
    function automatic logic float_keeps(input logic [31:0] st, input logic [31:0] fr);
        logic st_nan;
        logic fr_nan;
        logic both_zero;
        logic res;
        st_nan    = (st[30:23] == 8'hFF) && (st[22:0] != 23'd0);
        fr_nan    = (fr[30:23] == 8'hFF) && (fr[22:0] != 23'd0);
        both_zero = (st[30:0] == 31'd0) && (fr[30:0] == 31'd0);
        if (st_nan || fr_nan || both_zero) begin
            res = 1'b0;
        end else if (st[31] != fr[31]) begin
            res = !st[31];
        end else if (!st[31]) begin
            res = st[30:0] > fr[30:0];
        end else begin
            res = st[30:0] < fr[30:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* design/mp2d_ram.sv */
// ----------------------------------------------------------------------------
// mp2d_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/mp2d_div.sv */
// ----------------------------------------------------------------------------
// mp2d_div: small iterative divider
// Restoring division of a position by a stride, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2d_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [mp2d_pkg::POS_W-1:0]  dividend,
    input  wire logic [mp2d_pkg::STEP_W-1:0] divisor,
    output mp2d_pkg::div_res_t               res
);
    import mp2d_pkg::*;

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic [POS_W-1:0]  quot_reg, quot_next;
    logic [STEP_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0] dvs_reg, dvs_next;
    logic [STEP_W:0]   partial;
    logic [STEP_W:0]   diff;
    logic              ge;

    always_comb begin
        partial   = {rem_reg, quot_reg[POS_W-1]};
        ge        = partial >= {1'b0, dvs_reg};
        diff      = partial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quot_next = quot_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quot_next = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end else if (busy_reg) begin
            quot_next = {quot_reg[POS_W-2:0], ge};
            rem_next  = ge ? diff[STEP_W-1:0] : partial[STEP_W-1:0];
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == DCNT_W'(POS_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
    end

    assign res = '{done: done_reg, quot: quot_reg, rem: rem_reg};

endmodule

`default_nettype wire

/* design/max_pooling_2d_core.sv */
// ----------------------------------------------------------------------------
// max_pooling_2d_core: streaming 2-D max pooling of float32 feature maps
// Running window maxima kept in one RAM, updated read-modify-write.
// ----------------------------------------------------------------------------
// Samples arrive one per input transfer, channel fastest, then column, then
// row; tlast on the input marks the last sample of an image and returns the
// position counters to zero. Each sample is folded into every pool window of
// its channel that covers it: the first sample of a window is stored, later
// ones replace the stored value unless it is strictly greater (ties and NaN
// take the new sample). When the bottom-right sample of a window arrives its
// maximum leaves as one output transfer, with tlast set on the last window
// and channel of the image. A sample whose channel or column lies beyond the
// configured counts starts no division and leaves the core idle. Every other
// sample, even one that no window covers, passes through the row and column
// division by the strides (one quotient bit a cycle) and then a scan of the
// candidate windows, in which each covering window takes a RAM read, then a
// compare and write back, and each skipped candidate is passed over. The
// divider and the RAM port pair set the time a sample takes. The input is
// taken only while the core is idle. A finished result waits in the output
// register; it holds the core only when the next finishing window finds the
// register still full. Register writes take effect at once and belong
// between images. The window store is not cleared after reset: every window
// writes its first sample before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module max_pooling_2d_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port.
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [9:0]  cfg_wdata,
    // Input stream.
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // sample[31:0]
    input  wire logic        s_axis_tlast,  // last_in_image
    // Output stream.
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,  // pooled_value[31:0], out_col[36:32],
                                            // out_row[41:37], feature_index[50:42]
    output logic             m_axis_tlast   // image_done
);
    import mp2d_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_RMW  = 2'd3;

    // Raw configuration registers.
    logic [9:0] cc_reg;
    logic [7:0] iw_reg;
    logic [5:0] ow_reg, oh_reg;
    logic [2:0] ww_reg, wh_reg, sx_reg, sy_reg;

    // Effective values after clamping.
    logic [9:0] nc;
    logic [7:0] iw;
    logic [5:0] ow, oh;
    logic [2:0] ww, wh, sx, sy;

    logic [1:0]        state_reg, state_next;
    logic [CH_W-1:0]   chan_pos_reg, chan_pos_next;
    logic [POS_W-1:0]  col_pos_reg, col_pos_next;
    logic [POS_W-1:0]  row_pos_reg, row_pos_next;
    logic [DATA_W-1:0] smp_reg;
    logic [CH_W-1:0]   ch_reg;
    logic [POS_W-1:0]  oy_reg, oy_next, ox_reg, ox_next, qc_reg, qc_next;
    logic [OFS_W-1:0]  dy_reg, dy_next, dx_reg, dx_next;
    logic [STEP_W-1:0] remc_reg, remc_next;

    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_val_reg;
    logic [4:0]        m_col_reg, m_row_reg;
    logic [CH_W-1:0]   m_ch_reg;
    logic              m_last_reg;
    logic              out_load;

    logic              s_fire;
    logic              in_window;
    logic [9:0]        ch_inc;
    logic [7:0]        col_inc;
    logic              div_start;
    div_res_t          row_res, col_res;

    logic              ram_re, ram_we;
    logic [ADDR_W-1:0] ram_addr;
    logic [DATA_W-1:0] ram_rdata;
    logic [DATA_W-1:0] new_val;
    logic              first_smp, final_smp, img_done;

    // ---------------------------------------------------------------
    // Configuration registers. Zero acts as one; channel count, widths and window sizes saturate.
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_reg <= 10'd1;
            iw_reg <= 8'd1;
            ow_reg <= 6'd1;
            oh_reg <= 6'd1;
            ww_reg <= 3'd2;
            wh_reg <= 3'd2;
            sx_reg <= 3'd2;
            sy_reg <= 3'd2;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_CHANNEL_COUNT: cc_reg <= cfg_wdata;
                REG_INPUT_WIDTH:   iw_reg <= cfg_wdata[7:0];
                REG_OUTPUT_WIDTH:  ow_reg <= cfg_wdata[5:0];
                REG_OUTPUT_HEIGHT: oh_reg <= cfg_wdata[5:0];
                REG_WINDOW_WIDTH:  ww_reg <= cfg_wdata[2:0];
                REG_WINDOW_HEIGHT: wh_reg <= cfg_wdata[2:0];
                REG_STEP_X:        sx_reg <= cfg_wdata[2:0];
                REG_STEP_Y:        sy_reg <= cfg_wdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        nc = (cc_reg == 10'd0) ? 10'd1 :
             (cc_reg > 10'(MAX_CHANNELS)) ? 10'(MAX_CHANNELS) : cc_reg;
        iw = (iw_reg == 8'd0) ? 8'd1 :
             (iw_reg > 8'(MAX_IN_WIDTH)) ? 8'(MAX_IN_WIDTH) : iw_reg;
        ow = (ow_reg == 6'd0) ? 6'd1 :
             (ow_reg > 6'(MAX_OUT_WIDTH)) ? 6'(MAX_OUT_WIDTH) : ow_reg;
        oh = (oh_reg == 6'd0) ? 6'd1 : oh_reg;
        ww = (ww_reg == 3'd0) ? 3'd1 :
             (ww_reg > 3'(MAX_WINDOW)) ? 3'(MAX_WINDOW) : ww_reg;
        wh = (wh_reg == 3'd0) ? 3'd1 :
             (wh_reg > 3'(MAX_WINDOW)) ? 3'(MAX_WINDOW) : wh_reg;
        if (wh > 3'(ROWS_IN_FLIGHT)) begin
            wh = 3'(ROWS_IN_FLIGHT);
        end
        sx = (sx_reg == 3'd0) ? 3'd1 : sx_reg;
        sy = (sy_reg == 3'd0) ? 3'd1 : sy_reg;
    end

    // ---------------------------------------------------------------
    // Position counters advance on every accepted sample, or return to zero on tlast.
    // ---------------------------------------------------------------
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign in_window     = ({1'b0, chan_pos_reg} < nc) && ({1'b0, col_pos_reg} < iw);
    assign div_start     = s_fire && in_window;

    always_comb begin
        ch_inc        = {1'b0, chan_pos_reg} + 10'd1;
        col_inc       = {1'b0, col_pos_reg} + 8'd1;
        chan_pos_next = chan_pos_reg;
        col_pos_next  = col_pos_reg;
        row_pos_next  = row_pos_reg;
        if (s_fire) begin
            if (s_axis_tlast) begin
                chan_pos_next = '0;
                col_pos_next  = '0;
                row_pos_next  = '0;
            end else if (ch_inc >= nc) begin
                chan_pos_next = '0;
                if (col_inc >= iw) begin
                    col_pos_next = '0;
                    row_pos_next = row_pos_reg + 1'b1;
                end else begin
                    col_pos_next = col_inc[POS_W-1:0];
                end
            end else begin
                chan_pos_next = ch_inc[CH_W-1:0];
            end
        end
    end

    // Row and column are divided by the strides to find the last window
    // (quotient) and the offset into it (remainder).
    mp2d_div u_row_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (row_pos_reg),
        .divisor  (sy),
        .res      (row_res)
    );

    mp2d_div u_col_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (col_pos_reg),
        .divisor  (sx),
        .res      (col_res)
    );

    // ---------------------------------------------------------------
    // Window scan. Candidates are walked from the last window down,
    // rows outer and columns inner; the offset into the window grows by
    // the stride at each step until it leaves the window.
    // ---------------------------------------------------------------
    assign ram_addr  = {oy_reg[SLOT_W-1:0], ox_reg[OCOL_W-1:0], ch_reg};
    assign first_smp = (dy_reg == '0) && (dx_reg == '0);
    assign final_smp = (dy_reg == OFS_W'(wh - 3'd1)) && (dx_reg == OFS_W'(ww - 3'd1));
    assign img_done  = (oy_reg[5:0] == oh - 6'd1) && (ox_reg[5:0] == ow - 6'd1) &&
                       ({1'b0, ch_reg} == nc - 10'd1);
    assign new_val   = (first_smp || !float_keeps(ram_rdata, smp_reg)) ? smp_reg : ram_rdata;

    always_comb begin
        logic next_col;
        logic next_row;
        next_col     = 1'b0;
        next_row     = 1'b0;
        state_next   = state_reg;
        oy_next      = oy_reg;
        dy_next      = dy_reg;
        ox_next      = ox_reg;
        dx_next      = dx_reg;
        qc_next      = qc_reg;
        remc_next    = remc_reg;
        ram_re       = 1'b0;
        ram_we       = 1'b0;
        out_load     = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (div_start) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (row_res.done) begin
                    oy_next    = row_res.quot;
                    dy_next    = {1'b0, row_res.rem};
                    ox_next    = col_res.quot;
                    dx_next    = {1'b0, col_res.rem};
                    qc_next    = col_res.quot;
                    remc_next  = col_res.rem;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (dy_reg >= {1'b0, wh}) begin
                    state_next = ST_IDLE;
                end else if (dx_reg >= {1'b0, ww}) begin
                    next_row = 1'b1;
                end else if ((oy_reg < {1'b0, oh}) && (ox_reg < {1'b0, ow})) begin
                    ram_re     = 1'b1;
                    state_next = ST_RMW;
                end else begin
                    next_col = 1'b1;
                end
            end
            ST_RMW: begin
                // A finishing window waits here while the output is full.
                if (!(final_smp && m_valid_reg && !m_axis_tready)) begin
                    ram_we     = 1'b1;
                    out_load   = final_smp;
                    next_col   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (next_col) begin
            if (ox_reg == '0) begin
                next_row = 1'b1;
            end else begin
                ox_next = ox_reg - 1'b1;
                dx_next = dx_reg + OFS_W'(sx);
            end
        end
        if (next_row) begin
            if (oy_reg == '0) begin
                state_next = ST_IDLE;
            end else begin
                oy_next    = oy_reg - 1'b1;
                dy_next    = dy_reg + OFS_W'(sy);
                ox_next    = qc_reg;
                dx_next    = {1'b0, remc_reg};
                state_next = ST_SCAN;
            end
        end
    end

    mp2d_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (new_val),
        .re    (ram_re),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Output register.
    // ---------------------------------------------------------------
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            chan_pos_reg <= '0;
            col_pos_reg  <= '0;
            row_pos_reg  <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            chan_pos_reg <= chan_pos_next;
            col_pos_reg  <= col_pos_next;
            row_pos_reg  <= row_pos_next;
            m_valid_reg  <= m_valid_next;
        end
        if (s_fire) begin
            smp_reg <= s_axis_tdata;
            ch_reg  <= chan_pos_reg;
        end
        oy_reg   <= oy_next;
        dy_reg   <= dy_next;
        ox_reg   <= ox_next;
        dx_reg   <= dx_next;
        qc_reg   <= qc_next;
        remc_reg <= remc_next;
        if (out_load) begin
            m_val_reg  <= new_val;
            m_col_reg  <= ox_reg[4:0];
            m_row_reg  <= oy_reg[4:0];
            m_ch_reg   <= ch_reg;
            m_last_reg <= img_done;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'd0, m_ch_reg, m_row_reg, m_col_reg, m_val_reg};
    assign m_axis_tlast  = m_last_reg;

endmodule

`default_nettype wire

/* design/mp2d_checker.sv */
// ----------------------------------------------------------------------------
// mp2d_checker: port-level checks for the max pooling core
// Watches the stream ports and reset, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mp2d_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata,
    input wire logic        m_axis_tlast
);

    // A stalled result keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output payload changed while stalled");

    // A new result is produced only while the core is busy with a sample.
    a_out_from_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a sample in work");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind max_pooling_2d_core mp2d_checker u_mp2d_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* dv/tb_max_pooling_2d_core.sv */
// ----------------------------------------------------------------------------
// tb_max_pooling_2d_core: self-checking testbench for the max pooling core
// Streams float32 feature maps under several pool geometries, predicts every
// pooled value with a behavioral model of the window store and compares each
// output transfer field by field, with random idling on both stream sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_max_pooling_2d_core;
    timeunit 1ns;
    timeprecision 1ps;

    import mp2d_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    typedef struct packed {
        logic        image_done;
        logic [8:0]  feature_index;
        logic [4:0]  out_row;
        logic [4:0]  out_col;
        logic [31:0] pooled_value;
    } pooled_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [9:0]  cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        m_axis_tlast;

    max_pooling_2d_core i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Predictor state: register copies, position counters and window store.
    logic [9:0]  regs [8];
    logic [31:0] win_max [int];
    int unsigned chan_pos, col_pos, row_pos;
    pooled_t     expected_q [$];
    int          errors = 0;
    int          cycles = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    // A stored running maximum survives only if strictly greater than the
    // new sample; unordered operands and equal values, both zeros included,
    // let the new sample win.
    function automatic bit stored_wins(logic [31:0] st, logic [31:0] fr);
        bit st_nan, fr_nan;
        st_nan = (st[30:23] == 8'hFF) && (st[22:0] != 0);
        fr_nan = (fr[30:23] == 8'hFF) && (fr[22:0] != 0);
        if (st_nan || fr_nan) return 0;
        if (st[30:0] == 0 && fr[30:0] == 0) return 0;
        if (st[31] != fr[31]) return !st[31];
        if (!st[31]) return st[30:0] > fr[30:0];
        return st[30:0] < fr[30:0];
    endfunction

    function automatic int unsigned clip(int unsigned v, int unsigned hi);
        if (v == 0) return 1;
        return (v > hi) ? hi : v;
    endfunction

    // Fold one sample into every covering window and queue the finished one.
    task automatic pool_sample(logic [31:0] smp, logic last);
        int unsigned nc, iw, ow, oh, ww, wh, sx, sy, y0, x0, addr;
        logic [31:0] val;
        pooled_t res;
        nc = clip(regs[REG_CHANNEL_COUNT], MAX_CHANNELS);
        iw = clip(regs[REG_INPUT_WIDTH], 128);
        ow = clip(regs[REG_OUTPUT_WIDTH], MAX_OUT_WIDTH);
        oh = clip(regs[REG_OUTPUT_HEIGHT], 64);
        ww = clip(regs[REG_WINDOW_WIDTH], MAX_WINDOW);
        wh = clip(clip(regs[REG_WINDOW_HEIGHT], MAX_WINDOW), ROWS_IN_FLIGHT);
        sx = clip(regs[REG_STEP_X], 7);
        sy = clip(regs[REG_STEP_Y], 7);
        if (chan_pos < nc && col_pos < iw) begin
            for (int unsigned oy = 0; oy < oh; oy++) begin
                y0 = oy * sy;
                if (row_pos < y0 || row_pos >= y0 + wh) continue;
                for (int unsigned ox = 0; ox < ow; ox++) begin
                    x0 = ox * sx;
                    if (col_pos < x0 || col_pos >= x0 + ww) continue;
                    addr = ((oy % ROWS_IN_FLIGHT) * MAX_OUT_WIDTH + ox) * MAX_CHANNELS
                           + chan_pos;
                    if (row_pos == y0 && col_pos == x0) begin
                        val = smp;
                    end else begin
                        val = win_max.exists(addr) ? win_max[addr] : 32'h0;
                        if (!stored_wins(val, smp)) val = smp;
                    end
                    win_max[addr] = val;
                    if (row_pos == y0 + wh - 1 && col_pos == x0 + ww - 1) begin
                        res.pooled_value  = val;
                        res.out_col       = ox[4:0];
                        res.out_row       = oy[4:0];
                        res.feature_index = chan_pos[8:0];
                        res.image_done    = (oy == oh - 1 && ox == ow - 1 &&
                                             chan_pos == nc - 1);
                        expected_q.push_back(res);
                    end
                end
            end
        end
        if (last) begin
            chan_pos = 0; col_pos = 0; row_pos = 0;
        end else begin
            chan_pos++;
            if (chan_pos >= nc) begin
                chan_pos = 0;
                col_pos++;
                if (col_pos >= iw) begin
                    col_pos = 0;
                    row_pos = (row_pos + 1) & 7'h7F;
                end
            end
            chan_pos &= 9'h1FF;
            col_pos &= 7'h7F;
        end
    endtask

    // Send one sample; the expectation is formed when the transfer happens.
    // Valid stays high on return so samples can follow back to back; the
    // next call when it idles, or a register write, takes it down.
    task automatic send_sample(logic [31:0] smp, logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= last;
        do @(posedge aclk); while (!s_axis_tready);
        pool_sample(smp, last);
        @(negedge aclk);
    endtask

    // Registers are written only with the core idle: the queue is drained
    // and a pause covers any sample still being folded without a result.
    task automatic write_reg(logic [2:0] idx, logic [9:0] val);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        regs[idx] = val;
    endtask

    task automatic set_geometry(int nc, int ow, int oh, int ww, int wh, int sx, int sy);
        // Input width is chosen so the last window fits exactly.
        write_reg(REG_CHANNEL_COUNT, 10'(nc));
        write_reg(REG_OUTPUT_WIDTH, 10'(ow));
        write_reg(REG_OUTPUT_HEIGHT, 10'(oh));
        write_reg(REG_WINDOW_WIDTH, 10'(ww));
        write_reg(REG_WINDOW_HEIGHT, 10'(wh));
        write_reg(REG_STEP_X, 10'(sx));
        write_reg(REG_STEP_Y, 10'(sy));
        write_reg(REG_INPUT_WIDTH, 10'((ow - 1) * sx + ww));
    endtask

    function automatic logic [31:0] rand_float();
        case ($urandom_range(7))
            0: return {1'($urandom_range(1)), 31'h0};                  // signed zeros
            1: return {1'($urandom_range(1)), 8'hFF, 23'h0};          // infinities
            2: return {1'($urandom_range(1)), 8'hFF, 23'($urandom() | 1)};  // NaN
            3: return {1'($urandom_range(1)), 8'h7F, 23'($urandom_range(3))}; // near ties
            default: return $urandom();
        endcase
    endfunction

    // Stream one whole image of the current geometry, tlast on its last sample.
    task automatic send_image();
        int unsigned nc, iw, rows, total;
        nc = clip(regs[REG_CHANNEL_COUNT], MAX_CHANNELS);
        iw = clip(regs[REG_INPUT_WIDTH], 128);
        rows = (clip(regs[REG_OUTPUT_HEIGHT], 64) - 1) * clip(regs[REG_STEP_Y], 7)
               + clip(regs[REG_WINDOW_HEIGHT], 4);
        total = nc * iw * rows;
        for (int unsigned i = 0; i < total; i++) send_sample(rand_float(), i == total - 1);
    endtask

    // Directed: float corners under a single 2x2 window with stride 2.
    task automatic test_directed();
        logic [31:0] corners [12] = '{32'h0, 32'h8000_0000, 32'hFFFF_FFFF,
            32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000, 32'h3F80_0000,
            32'h3F80_0000, 32'hBF80_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'hFF7F_FFFF};
        set_geometry(1, 1, 1, 2, 2, 2, 2);
        for (int i = 0; i < 12; i++) send_sample(corners[i], i % 4 == 3);
        // One sample in the window and five outside it, then an early tlast mid-image.
        set_geometry(1, 1, 1, 1, 1, 3, 3);
        write_reg(REG_INPUT_WIDTH, 5);
        for (int i = 0; i < 6; i++) send_sample($urandom(), i == 5);
        send_sample(32'h4000_0000, 1'b1);
    endtask

    // Random images over many geometries, extremes included.
    task automatic test_random_images(int unsigned budget);
        int unsigned sent;
        int nc, ow, oh, ww, wh, sx, sy;
        sent = 0;
        while (sent < budget) begin
            case ($urandom_range(5))
                0: begin nc = 512; ow = 1; oh = 1; ww = 1; wh = 1; sx = 1; sy = 1; end
                1: begin nc = 1; ow = 32; oh = 2; ww = 4; wh = 1; sx = 4; sy = 4; end
                2: begin nc = 1; ow = 1; oh = 32; ww = 1; wh = 1; sx = 1; sy = 1; end
                default: begin
                    nc = $urandom_range(1, 4); ow = $urandom_range(1, 4);
                    oh = $urandom_range(1, 3); ww = $urandom_range(1, 4);
                    wh = $urandom_range(1, 4); sx = $urandom_range(1, 4);
                    sy = $urandom_range(1, 4);
                end
            endcase
            set_geometry(nc, ow, oh, ww, wh, sx, sy);
            sent += nc * regs[REG_INPUT_WIDTH] * ((oh - 1) * sy + wh);
            send_image();
        end
    endtask

    // Out-of-range register values: zeros act as one, big values saturate.
    task automatic test_register_limits();
        set_geometry(1, 1, 1, 1, 1, 1, 1);
        write_reg(REG_WINDOW_WIDTH, 0);
        write_reg(REG_WINDOW_HEIGHT, 7);
        write_reg(REG_STEP_X, 0);
        write_reg(REG_STEP_Y, 7);
        write_reg(REG_CHANNEL_COUNT, 0);
        write_reg(REG_OUTPUT_WIDTH, 0);
        write_reg(REG_OUTPUT_HEIGHT, 0);
        write_reg(REG_INPUT_WIDTH, 0);
        for (int i = 0; i < 16; i++) send_sample(rand_float(), i == 15);
        write_reg(REG_OUTPUT_WIDTH, 63);
        write_reg(REG_INPUT_WIDTH, 255);
        write_reg(REG_WINDOW_WIDTH, 1);
        write_reg(REG_WINDOW_HEIGHT, 1);
        write_reg(REG_STEP_X, 4);
        write_reg(REG_CHANNEL_COUNT, 1023);
        write_reg(REG_CHANNEL_COUNT, 1);
        for (int i = 0; i < 128; i++) send_sample(rand_float(), i == 127);
    endtask

    // Result checker: compare each output transfer with the oldest prediction.
    always @(posedge aclk) begin
        pooled_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got = {m_axis_tlast, m_axis_tdata[50:0]};
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (got !== want || m_axis_tdata[55:51] !== 5'b0) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want, got);
                    errors++;
                end
            end
        end
    end

    // Receiver backpressure follows the current idle percentage.
    always @(negedge aclk) m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < 8; i++) regs[i] = '0;
        regs[REG_CHANNEL_COUNT] = 1; regs[REG_INPUT_WIDTH] = 1;
        regs[REG_OUTPUT_WIDTH] = 1; regs[REG_OUTPUT_HEIGHT] = 1;
        regs[REG_WINDOW_WIDTH] = 2; regs[REG_WINDOW_HEIGHT] = 2;
        regs[REG_STEP_X] = 2; regs[REG_STEP_Y] = 2;
        chan_pos = 0; col_pos = 0; row_pos = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_idle_pct = 7;  recv_idle_pct = 58;
        test_directed();
        test_random_images(250);
        send_idle_pct = 58; recv_idle_pct = 7;
        test_random_images(250);
        test_register_limits();
        send_idle_pct = 0;  recv_idle_pct = 0;
        test_random_images(250);
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge aclk);
        repeat (300) @(negedge aclk);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
